// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
// Each macro expands to one labeled concurrent assertion on the given clock,
// disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property: the property expression is checked at every rising clock edge.
`define DPT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("device presence table assertion failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define DPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("device presence table assertion failed");

`endif

// ----- hdl/dpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dpt_pkg;

  // Default sizes of the table.
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int ID_BYTES_DEF    = 8;

  // Fixed field widths.
  localparam int ADDR_W  = 16;
  localparam int LEN_W   = 4;
  localparam int CD_W    = 8;
  localparam int KIND_W  = 3;
  localparam int IDIN_W  = 64;
  localparam int BYTE_W  = 8;

  // At most this many entries are removed by one tick.
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [CD_W-1:0] RELOAD_RESET = 8'd3;

  // Event kinds on the command channel.
  typedef enum logic [1:0] {
    OP_JOIN   = 2'd0,
    OP_BEAT   = 2'd1,
    OP_TICK   = 2'd2,
    OP_LOOKUP = 2'd3
  } op_e;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_JOINED  = 3'd0,
    KIND_OFFLINE = 3'd1,
    KIND_HIT     = 3'd2,
    KIND_MISS    = 3'd3,
    KIND_FULL    = 3'd4
  } kind_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WALK   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

endpackage

`default_nettype wire

// ----- hdl/dpt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/device_presence_table_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Presence table of joined network nodes.
// Commands: an event word (op, node address, id bytes, id length, key byte) is
// taken at a clock edge where start_i is high and busy_o is low. busy_o stays
// high until the event is fully processed.
// Results: each result word is shown for one cycle with result_valid_o high.
// The receiver cannot stall; a tick that removes several entries gives its
// result words in slot order, the final one with last_o set.
// Walk: every event walks the table one slot per cycle through the entry
// memory read port, from slot 0 up to the last slot, and then passes through
// a finish state. A join of a known node, a heartbeat that finds its node and
// a lookup hit end early, once the matching slot has been evaluated. A result
// is registered from the evaluation of the slot that causes it, or from the
// finish state after the walk ends.
// Configuration: cfg_we_i writes the heartbeat reload value; write it only
// while busy_o is low.
// Reset: all entries become invalid at once (valid bits in flip-flops), the
// reload value returns to 3. No clearing pass of the memory is needed.
module device_presence_table_core #(
  parameter int TABLE_DEPTH = dpt_pkg::TABLE_DEPTH_DEF,
  parameter int ID_BYTES    = dpt_pkg::ID_BYTES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [1:0]                  op_i,
  input  wire logic [dpt_pkg::ADDR_W-1:0]  node_addr_i,
  input  wire logic [dpt_pkg::IDIN_W-1:0]  id_value_i,
  input  wire logic [dpt_pkg::LEN_W-1:0]   id_length_i,
  input  wire logic [dpt_pkg::BYTE_W-1:0]  key_byte_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [dpt_pkg::CD_W-1:0]    cfg_wdata_i,
  output logic                             result_valid_o,
  output logic [dpt_pkg::KIND_W-1:0]       kind_o,
  output logic [dpt_pkg::BYTE_W-1:0]       first_id_byte_o,
  output logic [dpt_pkg::ADDR_W-1:0]       found_addr_o,
  output logic                             last_o
);

  localparam int ADDR_W = dpt_pkg::ADDR_W;
  localparam int LEN_W  = dpt_pkg::LEN_W;
  localparam int CD_W   = dpt_pkg::CD_W;
  localparam int BYTE_W = dpt_pkg::BYTE_W;
  localparam int CNT_W  = dpt_pkg::CNT_W;
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ID_W   = BYTE_W * ID_BYTES;
  localparam int ENT_W  = CD_W + LEN_W + ID_W + ADDR_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(ID_BYTES);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(dpt_pkg::MAX_RESULTS);

  // Control state.
  dpt_pkg::state_e         state_q, state_d;
  logic [TABLE_DEPTH-1:0]  valid_q, valid_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic                    free_found_q, free_found_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    pend_q, pend_d;
  logic                    res_valid_q, res_valid_d;
  logic [CD_W-1:0]         reload_q;

  // Payload registers.
  dpt_pkg::op_e            op_q, op_d;
  logic [ADDR_W-1:0]       addr_q, addr_d;
  logic [ID_W-1:0]         id_q, id_d;
  logic [LEN_W-1:0]        len_q, len_d;
  logic [BYTE_W-1:0]       key_q, key_d;
  logic [IDX_W-1:0]        free_idx_q, free_idx_d;
  logic [BYTE_W-1:0]       pend_byte_q, pend_byte_d;
  logic [ADDR_W-1:0]       pend_addr_q, pend_addr_d;
  dpt_pkg::kind_e          res_kind_q, res_kind_d;
  logic [BYTE_W-1:0]       res_byte_q, res_byte_d;
  logic [ADDR_W-1:0]       res_addr_q, res_addr_d;
  logic                    res_last_q, res_last_d;

  // Entry memory ports.
  logic                    ram_we, ram_re;
  logic [IDX_W-1:0]        ram_waddr, ram_raddr;
  logic [ENT_W-1:0]        ram_wdata, ram_rdata;

  // Fields of the entry under evaluation.
  logic [ADDR_W-1:0]       e_addr;
  logic [ID_W-1:0]         e_id;
  logic [LEN_W-1:0]        e_len;
  logic [CD_W-1:0]         e_cd;
  logic [CD_W-1:0]         cd_dec;
  logic                    e_valid;
  logic                    key_hit;
  logic                    last_slot;

  // Saturated length and masked id of the incoming word.
  logic [LEN_W-1:0]        len_sat;
  logic [ID_W-1:0]         id_masked;

  dpt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Clamp the id length into range and clear bytes beyond it.
  always_comb begin
    if (id_length_i == '0) begin
      len_sat = LEN_W'(1);
    end else if (id_length_i > LEN_MAX) begin
      len_sat = LEN_MAX;
    end else begin
      len_sat = id_length_i;
    end
    for (int b = 0; b < ID_BYTES; b++) begin
      id_masked[BYTE_W*b +: BYTE_W] = (LEN_W'(b) < len_sat) ?
                                      id_value_i[BYTE_W*b +: BYTE_W] : '0;
    end
  end

  // Unpack the entry read in the previous cycle.
  assign e_addr  = ram_rdata[ADDR_W-1:0];
  assign e_id    = ram_rdata[ADDR_W +: ID_W];
  assign e_len   = ram_rdata[ADDR_W+ID_W +: LEN_W];
  assign e_cd    = ram_rdata[ADDR_W+ID_W+LEN_W +: CD_W];
  assign e_valid = valid_q[idx_q];
  assign cd_dec  = (e_cd == '0) ? '0 : e_cd - CD_W'(1);
  assign last_slot = (idx_q == LAST_IDX);

  // Does the key byte appear within the stored id length?
  always_comb begin
    key_hit = 1'b0;
    for (int b = 0; b < ID_BYTES; b++) begin
      if ((LEN_W'(b) < e_len) && (e_id[BYTE_W*b +: BYTE_W] == key_q)) begin
        key_hit = 1'b1;
      end
    end
  end

  // Sequencer: walks the slots, reading one ahead while the current one is
  // evaluated and written back.
  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    idx_d        = idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    cnt_d        = cnt_q;
    pend_d       = pend_q;
    pend_byte_d  = pend_byte_q;
    pend_addr_d  = pend_addr_q;
    op_d         = op_q;
    addr_d       = addr_q;
    id_d         = id_q;
    len_d        = len_q;
    key_d        = key_q;
    res_valid_d  = 1'b0;
    res_kind_d   = res_kind_q;
    res_byte_d   = res_byte_q;
    res_addr_d   = res_addr_q;
    res_last_d   = res_last_q;
    ram_re       = 1'b0;
    ram_raddr    = idx_q + IDX_W'(1);
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = ram_rdata;

    unique case (state_q)
      dpt_pkg::ST_IDLE: begin
        if (start_i) begin
          op_d         = dpt_pkg::op_e'(op_i);
          addr_d       = node_addr_i;
          id_d         = id_masked;
          len_d        = len_sat;
          key_d        = key_byte_i;
          idx_d        = '0;
          free_found_d = 1'b0;
          cnt_d        = '0;
          pend_d       = 1'b0;
          ram_re       = 1'b1;
          ram_raddr    = '0;
          state_d      = dpt_pkg::ST_WALK;
        end
      end

      dpt_pkg::ST_WALK: begin
        ram_re = !last_slot;
        idx_d  = idx_q + IDX_W'(1);
        case (op_q)
          dpt_pkg::OP_JOIN: begin
            if (e_valid && (e_len == len_q) && (e_id == id_q)) begin
              // Known node: only the address changes.
              ram_we      = 1'b1;
              ram_wdata   = {e_cd, e_len, e_id, addr_q};
              res_valid_d = 1'b1;
              res_kind_d  = dpt_pkg::KIND_JOINED;
              res_byte_d  = e_id[BYTE_W-1:0];
              res_addr_d  = addr_q;
              res_last_d  = 1'b1;
              state_d     = dpt_pkg::ST_IDLE;
            end else if (!e_valid && !free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = idx_q;
            end
          end
          dpt_pkg::OP_BEAT: begin
            if (e_valid && (e_addr == addr_q)) begin
              ram_we    = 1'b1;
              ram_wdata = {reload_q, e_len, e_id, e_addr};
              state_d   = dpt_pkg::ST_IDLE;
            end
          end
          dpt_pkg::OP_TICK: begin
            if (e_valid) begin
              ram_we    = 1'b1;
              ram_wdata = {cd_dec, e_len, e_id, e_addr};
              if ((cd_dec == '0) && (cnt_q < CNT_MAX)) begin
                // Expired: remove it and hold its report back until the next
                // removal or the finish, so the final one can carry the last flag.
                valid_d[idx_q] = 1'b0;
                cnt_d          = cnt_q + CNT_W'(1);
                if (pend_q) begin
                  res_valid_d = 1'b1;
                  res_kind_d  = dpt_pkg::KIND_OFFLINE;
                  res_byte_d  = pend_byte_q;
                  res_addr_d  = pend_addr_q;
                  res_last_d  = 1'b0;
                end
                pend_d      = 1'b1;
                pend_byte_d = e_id[BYTE_W-1:0];
                pend_addr_d = e_addr;
              end
            end
          end
          dpt_pkg::OP_LOOKUP: begin
            if (e_valid && key_hit) begin
              res_valid_d = 1'b1;
              res_kind_d  = dpt_pkg::KIND_HIT;
              res_byte_d  = e_id[BYTE_W-1:0];
              res_addr_d  = e_addr;
              res_last_d  = 1'b1;
              state_d     = dpt_pkg::ST_IDLE;
            end
          end
          default: begin
          end
        endcase
        if ((state_d == dpt_pkg::ST_WALK) && last_slot) begin
          state_d = dpt_pkg::ST_FINISH;
        end
      end

      dpt_pkg::ST_FINISH: begin
        state_d    = dpt_pkg::ST_IDLE;
        res_last_d = 1'b1;
        case (op_q)
          dpt_pkg::OP_JOIN: begin
            res_valid_d = 1'b1;
            res_byte_d  = id_q[BYTE_W-1:0];
            res_addr_d  = addr_q;
            if (free_found_q) begin
              // New node goes into the lowest free slot.
              ram_we              = 1'b1;
              ram_waddr           = free_idx_q;
              ram_wdata           = {reload_q, len_q, id_q, addr_q};
              valid_d[free_idx_q] = 1'b1;
              res_kind_d          = dpt_pkg::KIND_JOINED;
            end else begin
              res_kind_d = dpt_pkg::KIND_FULL;
            end
          end
          dpt_pkg::OP_TICK: begin
            if (pend_q) begin
              res_valid_d = 1'b1;
              res_kind_d  = dpt_pkg::KIND_OFFLINE;
              res_byte_d  = pend_byte_q;
              res_addr_d  = pend_addr_q;
            end
            pend_d = 1'b0;
          end
          dpt_pkg::OP_LOOKUP: begin
            res_valid_d = 1'b1;
            res_kind_d  = dpt_pkg::KIND_MISS;
            res_byte_d  = '0;
            res_addr_d  = '0;
          end
          default: begin
          end
        endcase
      end

      default: begin
        state_d = dpt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dpt_pkg::ST_IDLE;
      valid_q      <= '0;
      idx_q        <= '0;
      free_found_q <= 1'b0;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      res_valid_q  <= 1'b0;
      reload_q     <= dpt_pkg::RELOAD_RESET;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      idx_q        <= idx_d;
      free_found_q <= free_found_d;
      cnt_q        <= cnt_d;
      pend_q       <= pend_d;
      res_valid_q  <= res_valid_d;
      if (cfg_we_i) begin
        reload_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    addr_q      <= addr_d;
    id_q        <= id_d;
    len_q       <= len_d;
    key_q       <= key_d;
    free_idx_q  <= free_idx_d;
    pend_byte_q <= pend_byte_d;
    pend_addr_q <= pend_addr_d;
    res_kind_q  <= res_kind_d;
    res_byte_q  <= res_byte_d;
    res_addr_q  <= res_addr_d;
    res_last_q  <= res_last_d;
  end

  assign busy_o          = (state_q != dpt_pkg::ST_IDLE);
  assign result_valid_o  = res_valid_q;
  assign kind_o          = res_kind_q;
  assign first_id_byte_o = res_byte_q;
  assign found_addr_o    = res_addr_q;
  assign last_o          = res_last_q;

endmodule

`default_nettype wire

// ----- hdl/dpt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dpt_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start_i,
  input wire logic                       busy_o,
  input wire logic                       result_valid_o,
  input wire logic [dpt_pkg::KIND_W-1:0] kind_o,
  input wire logic [dpt_pkg::BYTE_W-1:0] first_id_byte_o,
  input wire logic [dpt_pkg::ADDR_W-1:0] found_addr_o,
  input wire logic                       last_o
);

  // An accepted command word makes the block busy in the next cycle.
  `DPT_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)

  // Result words only come out of an event that was being processed.
  `DPT_ASSERT(a_result_after_busy, clk_i, rst_ni, result_valid_o |-> $past(busy_o))

  // Only a tick gives more than one result word per event.
  `DPT_ASSERT(a_single_is_last, clk_i, rst_ni,
    (result_valid_o && (kind_o != dpt_pkg::KIND_OFFLINE)) |-> last_o)

  // A lookup miss reports no entry.
  `DPT_ASSERT(a_miss_zero, clk_i, rst_ni,
    (result_valid_o && (kind_o == dpt_pkg::KIND_MISS)) |->
      ((first_id_byte_o == '0) && (found_addr_o == '0)))

endmodule

bind device_presence_table_core dpt_checker u_dpt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .result_valid_o  (result_valid_o),
  .kind_o          (kind_o),
  .first_id_byte_o (first_id_byte_o),
  .found_addr_o    (found_addr_o),
  .last_o          (last_o)
);

`default_nettype wire
